### hw/rtl/overlap_add_fir_convolver_top_assert.svh
// assertion macros for the overlap-add convolver
`ifndef OVERLAP_ADD_FIR_CONVOLVER_TOP_ASSERT_SVH
`define OVERLAP_ADD_FIR_CONVOLVER_TOP_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define OFC_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// condition holds at every clock edge out of reset
`define OFC_ASSERT_ALWAYS(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
        else $error(msg);

`endif

### hw/rtl/ofc_pkg.sv
// shared types and constants of the overlap-add convolver
package ofc_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int TAP_W      = 16;
    localparam int PROD_W     = SAMPLE_W + TAP_W;
    localparam int RESULT_W   = 36;
    localparam int MAX_TAPS   = 16;
    localparam int TAP_IW     = 4;
    localparam int TAIL_DEPTH = 15;
    localparam int TAIL_IW    = 4;
    localparam int ADDR_W     = 6;
    localparam int DATA_W     = 64;

    // register index, paddr[5:3]
    localparam logic [2:0] REG_TAP_COUNT    = 3'd0;
    localparam logic [2:0] REG_BLOCK_LENGTH = 3'd1;
    localparam logic [2:0] REG_TAPS_0_3     = 3'd2;
    localparam logic [2:0] REG_TAPS_4_7     = 3'd3;
    localparam logic [2:0] REG_TAPS_8_11    = 3'd4;
    localparam logic [2:0] REG_TAPS_12_15   = 3'd5;

    typedef struct packed {
        logic                       final_sample;
        logic signed [SAMPLE_W-1:0] sample;
    } in_t;

    typedef struct packed {
        logic                       sequence_end;
        logic                       last_of_run;
        logic signed [RESULT_W-1:0] result;
    } out_t;

    typedef struct packed {
        logic [MAX_TAPS-1:0][TAP_W-1:0] taps;
        logic [5:0]                     block_length;
        logic [4:0]                     tap_count;
    } cfg_t;

    // control that travels with one multiply-accumulate issue
    typedef struct packed {
        logic act;
        logic term;
        logic first;
        logic last;
    } mac_ctl_t;

endpackage

### hw/rtl/ofc_ram.sv
// generic single-port-write ram with registered read
module ofc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 48
) (
    input  logic                                       aclk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;
endmodule

### hw/rtl/ofc_cfg.sv
// apb register file: tap count, block length and packed taps
module ofc_cfg (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ofc_pkg::ADDR_W-1:0]  paddr,
    input  logic [ofc_pkg::DATA_W-1:0]  pwdata,
    output logic [ofc_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output ofc_pkg::cfg_t               cfg
);
    import ofc_pkg::*;

    cfg_t       cfg_reg, cfg_next;
    logic [2:0] idx;
    logic       wr_en;

    assign idx    = paddr[ADDR_W-1:3];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (idx)
                REG_TAP_COUNT:    cfg_next.tap_count      = pwdata[4:0];
                REG_BLOCK_LENGTH: cfg_next.block_length   = pwdata[5:0];
                REG_TAPS_0_3:     cfg_next.taps[3:0]      = pwdata;
                REG_TAPS_4_7:     cfg_next.taps[7:4]      = pwdata;
                REG_TAPS_8_11:    cfg_next.taps[11:8]     = pwdata;
                REG_TAPS_12_15:   cfg_next.taps[15:12]    = pwdata;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_TAP_COUNT:    prdata = {{(DATA_W-5){1'b0}}, cfg_reg.tap_count};
            REG_BLOCK_LENGTH: prdata = {{(DATA_W-6){1'b0}}, cfg_reg.block_length};
            REG_TAPS_0_3:     prdata = cfg_reg.taps[3:0];
            REG_TAPS_4_7:     prdata = cfg_reg.taps[7:4];
            REG_TAPS_8_11:    prdata = cfg_reg.taps[11:8];
            REG_TAPS_12_15:   prdata = cfg_reg.taps[15:12];
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.tap_count    <= 5'd1;
            cfg_reg.block_length <= 6'd8;
            cfg_reg.taps         <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;
endmodule

### hw/rtl/ofc_mac.sv
// shared pipelined multiply-accumulate unit
module ofc_mac (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  ofc_pkg::mac_ctl_t                    iss_ctl,
    input  logic signed [ofc_pkg::RESULT_W-1:0]  iss_init,
    input  logic signed [ofc_pkg::TAP_W-1:0]     iss_tap,
    input  logic signed [ofc_pkg::SAMPLE_W-1:0]  rd_sample,
    output logic signed [ofc_pkg::RESULT_W-1:0]  acc,
    output logic                                 done
);
    import ofc_pkg::*;

    mac_ctl_t                   ctl_s1_reg, ctl_s2_reg;
    logic signed [TAP_W-1:0]    tap_s1_reg;
    logic signed [RESULT_W-1:0] init_s1_reg, init_s2_reg;
    logic signed [PROD_W-1:0]   prod_full;
    logic signed [PROD_W-1:0]   prod_reg, prod_next;
    logic signed [RESULT_W-1:0] acc_reg, acc_next;
    logic                       done_reg, done_next;

    // sample read data lines up with stage one
    // product kept in its own signed context so both factors sign-extend
    assign prod_full = tap_s1_reg * rd_sample;
    assign prod_next = ctl_s1_reg.term ? prod_full : '0;

    always_comb begin
        acc_next  = acc_reg;
        done_next = ctl_s2_reg.act && ctl_s2_reg.last;
        if (ctl_s2_reg.act) begin
            acc_next = (ctl_s2_reg.first ? init_s2_reg : acc_reg) + RESULT_W'(prod_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_s1_reg <= '0;
            ctl_s2_reg <= '0;
            done_reg   <= 1'b0;
        end else begin
            ctl_s1_reg <= iss_ctl;
            ctl_s2_reg <= ctl_s1_reg;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        tap_s1_reg  <= iss_tap;
        init_s1_reg <= iss_init;
        init_s2_reg <= init_s1_reg;
        prod_reg    <= prod_next;
        acc_reg     <= acc_next;
    end

    assign acc  = acc_reg;
    assign done = done_reg;
endmodule

### hw/rtl/overlap_add_fir_convolver_top.sv
// top level of the overlap-add block convolver
//
// input channel s_valid/s_ready/s_data carries one signed sample per transfer,
// with final_sample marking the last sample of a sequence. samples are stored
// until a block of block_length closes (or final_sample arrives), then the
// block is convolved with tap_count taps through one shared multiply-accumulate
// unit and results leave on m_valid/m_ready/m_data.
// a sample that does not close a block is only stored, and s_ready stays high.
// a closing sample makes c+M-1 sums (c samples held); each sum is issued tap
// by tap through the mac, passes its pipeline registers, and a final step hands
// the sum to the output register or the overlap tail. a full block sends c
// results, a final block c+M-1, and last_of_run flags the last one.
// s_ready is low from a closing transfer until its last sum is done.
// the output register holds one result; if the receiver stalls the sequencer
// waits on it, and the next sample can be taken while the final result waits.
// reset (aresetn low, synchronous) clears the fill count, the overlap tail,
// the sequencer and the output valid; registers return to M=1, L=8, taps zero.
// configuration is over apb, 64-bit registers at 8-byte spacing.
`include "overlap_add_fir_convolver_top_assert.svh"

module overlap_add_fir_convolver_top #(
    parameter int MAX_BLOCK = 48
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // sample channel
    input  logic                        s_valid,
    output logic                        s_ready,
    input  ofc_pkg::in_t                s_data,
    // result channel
    output logic                        m_valid,
    input  logic                        m_ready,
    output ofc_pkg::out_t               m_data,
    // configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ofc_pkg::ADDR_W-1:0]  paddr,
    input  logic [ofc_pkg::DATA_W-1:0]  pwdata,
    output logic [ofc_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);
    import ofc_pkg::*;

    localparam int AW = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
    localparam int FW = $clog2(MAX_BLOCK + 1);
    localparam int JW = $clog2(MAX_BLOCK + TAIL_DEPTH + 1);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MAC  = 4'b0010,
        ST_WAIT = 4'b0100,
        ST_OUT  = 4'b1000
    } state_t;

    cfg_t cfg;

    state_t         state_reg, state_next;
    logic [FW-1:0]  fill_reg, fill_next;
    logic [FW-1:0]  c_reg, c_next;
    logic           fin_reg, fin_next;
    logic [JW-1:0]  j_reg, j_next;
    logic [TAP_IW-1:0] k_reg, k_next;
    logic           m_valid_reg, m_valid_next;
    out_t           m_data_reg, m_data_next;

    logic signed [RESULT_W-1:0] tail_reg  [TAIL_DEPTH];
    logic signed [RESULT_W-1:0] tail_next [TAIL_DEPTH];

    // effective configuration
    logic [4:0]    eff_m;
    logic [FW-1:0] eff_l;

    // sample write side
    logic          s_fire;
    logic [FW-1:0] wr_idx, count_after;
    logic          closes;

    // sequencer terms
    logic [JW-1:0] total_w, emit_w, diff_w, tw_diff;
    logic          term, first_k, last_k, tail_hit, emit_now, out_free, advance;
    logic [TAIL_IW-1:0] tidx;

    // mac interface
    mac_ctl_t                   iss_ctl;
    logic signed [RESULT_W-1:0] iss_init;
    logic signed [TAP_W-1:0]    iss_tap;
    logic signed [SAMPLE_W-1:0] rd_sample;
    logic signed [RESULT_W-1:0] mac_acc;
    logic                       mac_done;
    logic [AW-1:0]              rd_addr;

    ofc_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // zero counts as one, too large clamps to the maximum
    always_comb begin
        if (cfg.tap_count == 5'd0) begin
            eff_m = 5'd1;
        end else if (cfg.tap_count > 5'(MAX_TAPS)) begin
            eff_m = 5'(MAX_TAPS);
        end else begin
            eff_m = cfg.tap_count;
        end
        if (cfg.block_length == 6'd0) begin
            eff_l = FW'(1);
        end else if (cfg.block_length > 6'(MAX_BLOCK)) begin
            eff_l = FW'(MAX_BLOCK);
        end else begin
            eff_l = FW'(cfg.block_length);
        end
    end

    assign s_ready     = (state_reg == ST_IDLE);
    assign s_fire      = s_valid && s_ready;
    assign wr_idx      = (fill_reg >= FW'(MAX_BLOCK)) ? FW'(MAX_BLOCK - 1) : fill_reg;
    assign count_after = wr_idx + FW'(1);
    assign closes      = s_data.final_sample || (count_after >= eff_l);

    ofc_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_BLOCK)
    ) u_block_store (
        .aclk  (aclk),
        .we    (s_fire),
        .waddr (wr_idx[AW-1:0]),
        .wdata (s_data.sample),
        .raddr (rd_addr),
        .rdata (rd_sample)
    );

    // output j sums taps k against sample j-k of the held block
    assign total_w  = JW'(c_reg) + JW'(eff_m) - JW'(1);
    assign emit_w   = fin_reg ? total_w : JW'(c_reg);
    assign diff_w   = j_reg - JW'(k_reg);
    assign rd_addr  = diff_w[AW-1:0];
    assign term     = (JW'(k_reg) <= j_reg) && (diff_w < JW'(c_reg));
    assign first_k  = (k_reg == '0);
    assign last_k   = (5'(k_reg) == eff_m - 5'd1);
    assign tail_hit = (j_reg < JW'(eff_m) - JW'(1));
    assign tidx     = j_reg[TAIL_IW-1:0];
    assign tw_diff  = j_reg - JW'(c_reg);

    assign emit_now = (j_reg < emit_w);
    assign out_free = !m_valid_reg || m_ready;
    assign advance  = (state_reg == ST_OUT) && (!emit_now || out_free);

    always_comb begin
        iss_ctl       = '0;
        iss_ctl.act   = (state_reg == ST_MAC);
        iss_ctl.term  = term;
        iss_ctl.first = first_k;
        iss_ctl.last  = last_k;
        iss_tap       = cfg.taps[k_reg];
        iss_init      = (first_k && tail_hit) ? tail_reg[tidx] : '0;
    end

    ofc_mac u_mac (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .iss_ctl   (iss_ctl),
        .iss_init  (iss_init),
        .iss_tap   (iss_tap),
        .rd_sample (rd_sample),
        .acc       (mac_acc),
        .done      (mac_done)
    );

    // sequencer
    always_comb begin
        state_next = state_reg;
        fill_next  = fill_reg;
        c_next     = c_reg;
        fin_next   = fin_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    if (closes) begin
                        c_next     = count_after;
                        fin_next   = s_data.final_sample;
                        fill_next  = '0;
                        j_next     = '0;
                        k_next     = '0;
                        state_next = ST_MAC;
                    end else begin
                        fill_next = count_after;
                    end
                end
            end
            ST_MAC: begin
                k_next = k_reg + TAP_IW'(1);
                if (last_k) begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (mac_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (advance) begin
                    j_next = j_reg + JW'(1);
                    k_next = '0;
                    state_next = (j_reg + JW'(1) == total_w) ? ST_IDLE : ST_MAC;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // overlap tail: cleared as it is read, refilled from sums past the block
    always_comb begin
        for (int i = 0; i < TAIL_DEPTH; i++) begin
            tail_next[i] = tail_reg[i];
            if (state_reg == ST_MAC && first_k) begin
                if (j_reg == '0 && 5'(i) >= eff_m - 5'd1) begin
                    tail_next[i] = '0;
                end
                if (tail_hit && tidx == TAIL_IW'(i)) begin
                    tail_next[i] = '0;
                end
            end
            if (advance && !fin_reg && !emit_now && tw_diff[TAIL_IW-1:0] == TAIL_IW'(i)) begin
                tail_next[i] = mac_acc;
            end
        end
    end

    // output register
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (advance && emit_now) begin
            m_valid_next             = 1'b1;
            m_data_next.result       = mac_acc;
            m_data_next.last_of_run  = (j_reg + JW'(1) == emit_w);
            m_data_next.sequence_end = (j_reg + JW'(1) == emit_w) && fin_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            fill_reg    <= '0;
            c_reg       <= '0;
            fin_reg     <= 1'b0;
            j_reg       <= '0;
            k_reg       <= '0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < TAIL_DEPTH; i++) begin
                tail_reg[i] <= '0;
            end
        end else begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            c_reg       <= c_next;
            fin_reg     <= fin_next;
            j_reg       <= j_next;
            k_reg       <= k_next;
            m_valid_reg <= m_valid_next;
            for (int i = 0; i < TAIL_DEPTH; i++) begin
                tail_reg[i] <= tail_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // mac finishes a sum only while the sequencer waits for it
    `OFC_ASSERT_IMPLIES(a_done_in_wait, aclk, aresetn, mac_done, state_reg == ST_WAIT, "mac done outside wait")
    // fill count never reaches the store depth
    `OFC_ASSERT_ALWAYS(a_fill_bound, aclk, aresetn, fill_reg < FW'(MAX_BLOCK), "fill count overflow")
    // the end of a sequence is always the last result of its run
    `OFC_ASSERT_IMPLIES(a_end_is_last, aclk, aresetn, m_valid_reg && m_data_reg.sequence_end, m_data_reg.last_of_run, "sequence end without last of run")
endmodule
